/* src/rfm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rfm_pkg
// Shared codes, widths and reset values for the round-trip-time
// failure monitor.
// ---------------------------------------------------------------------------
package rfm_pkg;

   localparam int unsigned OP_W     = 2;
   localparam int unsigned STATE_W  = 2;
   localparam int unsigned RTT_W    = 16;
   localparam int unsigned CAP_W    = 15;
   localparam int unsigned TMO_W    = 16;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 16;

   typedef enum logic [OP_W-1:0] {
      OP_RESTART = 2'd0,
      OP_SAMPLE  = 2'd1,
      OP_TIMEOUT = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   localparam logic [STATE_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATE_W-1:0] ST_TMP  = 2'd1;
   localparam logic [STATE_W-1:0] ST_PERM = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_RTT_CAP      = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_TIMEOUT = 1'd1;

   localparam logic [CAP_W-1:0] RESET_RTT_CAP      = 15'd30000;
   localparam logic [TMO_W-1:0] RESET_INIT_TIMEOUT = 16'd5000;

endpackage : rfm_pkg
`default_nettype wire

/* src/rtt_failure_monitor_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: an accepted word goes into the input register, then the result
//   register that drives rsp_valid; rsp_stall can hold it in the input register.
// Throughput: one word per cycle while rsp_stall is low; the estimator update
//   runs as one short path from the input register and the avg/dev registers
//   into the result register. Reset (synchronous): both stages empty,
//   rtt_cap 30000, initial_timeout 5000, avg and dev zero, current timeout 5000.
// ---------------------------------------------------------------------------
// rtt_failure_monitor_unit
// Round-trip-time estimator and peer fault-state monitor: one event word in,
// one result word out with state change and timer rearm value.
// ---------------------------------------------------------------------------
module rtt_failure_monitor_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [rfm_pkg::OP_W-1:0]        req_op,
   input  wire logic [rfm_pkg::STATE_W-1:0]     req_site_state,
   input  wire logic [rfm_pkg::RTT_W-1:0]       req_rtt_sample,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [rfm_pkg::STATE_W-1:0]          rsp_next_state,
   output logic                                 rsp_state_changed,
   output logic                                 rsp_rearm,
   output logic [rfm_pkg::TMO_W-1:0]            rsp_timeout_value,
   input  wire logic                            csr_write_enable,
   input  wire logic [rfm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [rfm_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import rfm_pkg::*;

   logic [CAP_W-1:0]     rtt_cap_ff;
   logic [TMO_W-1:0]     init_tmo_ff;
   logic [RTT_W-1:0]     avg_ff, avg_in;
   logic [RTT_W-1:0]     dev_ff, dev_in;
   logic [TMO_W-1:0]     tmo_ff, tmo_in;

   logic                 in_valid_ff;
   op_type               in_op_ff;
   logic [STATE_W-1:0]   in_state_ff;
   logic [RTT_W-1:0]     in_sample_ff;

   logic                 out_valid_ff;
   logic [STATE_W-1:0]   out_state_ff, out_state_in;
   logic                 out_changed_ff, out_changed_in;
   logic                 out_rearm_ff, out_rearm_in;
   logic [TMO_W-1:0]     out_tmo_ff, out_tmo_in;

   logic                 advance;
   logic                 load_in;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign load_in   = !req_stall;

   always_comb begin
      logic [STATE_W-1:0]  st;
      logic [CAP_W-1:0]    s;
      logic signed [17:0]  err, err_adj, half, abs_err, dd, dd_adj, quarter;
      logic signed [17:0]  avg_s, dev_s;
      logic [RTT_W-1:0]    avg_n, dev_n;
      logic [RTT_W:0]      sum;

      st = (in_state_ff > ST_PERM) ? ST_PERM : in_state_ff;
      s  = (in_sample_ff > {1'b0, rtt_cap_ff}) ? rtt_cap_ff : in_sample_ff[CAP_W-1:0];

      err     = $signed({3'b000, s}) - $signed({2'b00, avg_ff});
      err_adj = err + $signed({17'd0, err[17]});
      half    = err_adj >>> 1;
      abs_err = err[17] ? -err : err;
      dd      = abs_err - $signed({2'b00, dev_ff});
      dd_adj  = dd + $signed({16'd0, dd[17], dd[17]});
      quarter = dd_adj >>> 2;
      avg_s   = $signed({2'b00, avg_ff}) + half;
      dev_s   = $signed({2'b00, dev_ff}) + quarter;

      if (avg_ff != '0) begin
         avg_n = avg_s[RTT_W-1:0];
         dev_n = dev_s[RTT_W-1:0];
      end else begin
         avg_n = {1'b0, s};
         dev_n = {1'b0, s};
      end
      sum = {1'b0, avg_n} + {1'b0, dev_n};

      avg_in         = avg_ff;
      dev_in         = dev_ff;
      tmo_in         = tmo_ff;
      out_state_in   = st;
      out_changed_in = 1'b0;
      out_rearm_in   = 1'b0;
      out_tmo_in     = '0;

      case (in_op_ff)
         OP_RESTART: begin
            avg_in       = '0;
            tmo_in       = init_tmo_ff;
            out_rearm_in = 1'b1;
            out_tmo_in   = init_tmo_ff;
         end
         OP_SAMPLE: begin
            if (st != ST_PERM) begin
               if (st == ST_TMP) begin
                  out_state_in   = ST_OK;
                  out_changed_in = 1'b1;
               end
               avg_in       = avg_n;
               dev_in       = dev_n;
               tmo_in       = sum[TMO_W-1:0];
               out_rearm_in = 1'b1;
               out_tmo_in   = sum[TMO_W-1:0];
            end
         end
         OP_TIMEOUT: begin
            if (st != ST_PERM) begin
               if (st == ST_OK) begin
                  out_state_in   = ST_TMP;
                  out_changed_in = 1'b1;
               end
               out_rearm_in = 1'b1;
               out_tmo_in   = tmo_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rtt_cap_ff   <= RESET_RTT_CAP;
         init_tmo_ff  <= RESET_INIT_TIMEOUT;
         avg_ff       <= '0;
         dev_ff       <= '0;
         tmo_ff       <= RESET_INIT_TIMEOUT;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_RTT_CAP:      rtt_cap_ff  <= csr_wdata[CAP_W-1:0];
               CSR_INIT_TIMEOUT: init_tmo_ff <= csr_wdata[TMO_W-1:0];
               default: begin
               end
            endcase
         end
         if (load_in) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            avg_ff       <= avg_in;
            dev_ff       <= dev_in;
            tmo_ff       <= tmo_in;
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_in) begin
         in_op_ff     <= op_type'(req_op);
         in_state_ff  <= req_site_state;
         in_sample_ff <= req_rtt_sample;
      end
      if (advance) begin
         out_state_ff   <= out_state_in;
         out_changed_ff <= out_changed_in;
         out_rearm_ff   <= out_rearm_in;
         out_tmo_ff     <= out_tmo_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_next_state    = out_state_ff;
   assign rsp_state_changed = out_changed_ff;
   assign rsp_rearm         = out_rearm_ff;
   assign rsp_timeout_value = out_tmo_ff;

`ifndef SYNTHESIS
   a_est_range: assert property (@(posedge clock) disable iff (reset)
      !avg_ff[RTT_W-1] && !dev_ff[RTT_W-1])
      else $error("estimator left its range");

   a_hold_state: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(avg_ff) && $stable(dev_ff) && $stable(tmo_ff))
      else $error("estimator changed without a word");

   a_no_rearm_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_rearm |-> rsp_timeout_value == '0)
      else $error("timeout value without rearm");

   a_change_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_state_changed |-> rsp_rearm && rsp_next_state != ST_PERM)
      else $error("bad state change");
`endif
endmodule : rtt_failure_monitor_unit
`default_nettype wire
